@@ src/obc_pkg.sv @@
// Shared types, constants and the CORDIC arctangent table for the oriented box corner core.
// No dependencies; every other file depends on it.
`default_nettype none

package obc_pkg;

  localparam int unsigned MaxStages = 24;
  localparam int unsigned CordicW   = 34;

  localparam logic signed [CordicW-1:0] GainQ30   = 34'sd652032874;
  localparam logic signed [CordicW-1:0] PiQ30     = 34'sd3373259426;
  localparam logic signed [CordicW-1:0] HalfPiQ30 = 34'sd1686629713;

  localparam logic signed [25:0] OutMax = 26'sd8388607;
  localparam logic signed [25:0] OutMin = -26'sd8388608;

  typedef struct packed {
    logic        [15:0] obj_length;
    logic        [15:0] obj_width;
    logic        [15:0] obj_height;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] roll_angle;
    logic signed [23:0] ref_x;
    logic signed [23:0] ref_y;
  } pose_t;

  typedef struct packed {
    logic signed [23:0] rear_right_x;
    logic signed [23:0] rear_right_y;
    logic signed [23:0] rear_left_x;
    logic signed [23:0] rear_left_y;
    logic signed [23:0] front_left_x;
    logic signed [23:0] front_left_y;
    logic signed [23:0] front_right_x;
    logic signed [23:0] front_right_y;
  } corners_t;

  typedef struct packed {
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic signed [CordicW-1:0] z;
    logic                      neg;
  } cordic_t;

  typedef struct packed {
    logic        [15:0] len;
    logic        [15:0] wid;
    logic        [15:0] hgt;
    logic               roll_neg;
    logic               roll_pos;
    logic signed [23:0] ref_x;
    logic signed [23:0] ref_y;
  } side_t;

  function automatic logic signed [CordicW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [CordicW-1:0] v;
    v = '0;
    case (idx)
      5'd0:  v = 34'sh3243F6A8;
      5'd1:  v = 34'sh1DAC6705;
      5'd2:  v = 34'sh0FADBAFC;
      5'd3:  v = 34'sh07F56EA6;
      5'd4:  v = 34'sh03FEAB76;
      5'd5:  v = 34'sh01FFD55B;
      5'd6:  v = 34'sh00FFFAAA;
      5'd7:  v = 34'sh007FFF55;
      5'd8:  v = 34'sh003FFFEA;
      5'd9:  v = 34'sh001FFFFD;
      5'd10: v = 34'sh000FFFFF;
      5'd11: v = 34'sh0007FFFF;
      5'd12: v = 34'sh0003FFFF;
      5'd13: v = 34'sh0001FFFF;
      5'd14: v = 34'sh0000FFFF;
      5'd15: v = 34'sh00007FFF;
      5'd16: v = 34'sh00003FFF;
      5'd17: v = 34'sh00001FFF;
      5'd18: v = 34'sh00000FFF;
      5'd19: v = 34'sh000007FF;
      5'd20: v = 34'sh000003FF;
      5'd21: v = 34'sh000001FF;
      5'd22: v = 34'sh000000FF;
      5'd23: v = 34'sh0000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ src/obc_if.sv @@
// Valid/ready channel interfaces for pose words in and corner words out.
// Depends on obc_pkg for the payload types.
`default_nettype none

interface obc_in_if;
  logic          valid;
  logic          ready;
  obc_pkg::pose_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface obc_out_if;
  logic             valid;
  logic             ready;
  obc_pkg::corners_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/obc_cordic_stage.sv @@
// One registered CORDIC rotation step, applied to the yaw and the roll rotator side by side.
// Depends on obc_pkg for the rotator state type and the arctangent table.
`default_nettype none

module obc_cordic_stage #(
  parameter int unsigned SHIFT = 0
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 en_i,
  input  wire                 valid_i,
  input  obc_pkg::cordic_t    yaw_i,
  input  obc_pkg::cordic_t    roll_i,
  output logic                valid_o,
  output obc_pkg::cordic_t    yaw_o,
  output obc_pkg::cordic_t    roll_o
);
  import obc_pkg::*;

  localparam logic signed [CordicW-1:0] Atan = atan_q30(5'(SHIFT));

  function automatic cordic_t rotate(input cordic_t c);
    cordic_t r;
    r = c;
    if (c.z >= 0) begin
      r.x = c.x - (c.y >>> SHIFT);
      r.y = c.y + (c.x >>> SHIFT);
      r.z = c.z - Atan;
    end else begin
      r.x = c.x + (c.y >>> SHIFT);
      r.y = c.y - (c.x >>> SHIFT);
      r.z = c.z + Atan;
    end
    return r;
  endfunction

  logic    valid_q;
  cordic_t yaw_q, roll_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yaw_q  <= rotate(yaw_i);
      roll_q <= rotate(roll_i);
    end
  end

  assign valid_o = valid_q;
  assign yaw_o   = yaw_q;
  assign roll_o  = roll_q;

endmodule

`default_nettype wire

@@ src/oriented_box_corners_core.sv @@
// Top level of the oriented box corner core: pose words in, four saturated ground corners out.
// Depends on obc_pkg, obc_if and obc_cordic_stage.
`default_nettype none

// Takes one pose word per cycle and returns one corner word per pose, in order. It has
// one input stage, one CORDIC stage per iteration, then rounding, two multiplier stages
// with an offset adder between them, a rounding stage and the saturating output register.
// The pipeline advances as a whole and holds while a finished word waits at the output.
module oriented_box_corners_core #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  obc_in_if.sink    in_i,
  obc_out_if.source out_o
);
  import obc_pkg::*;

  localparam int unsigned NS = (CORDIC_STAGES < MaxStages) ? CORDIC_STAGES : MaxStages;

  logic en;

  // Input stage: reduce angles into the CORDIC range.
  function automatic cordic_t seed(input logic signed [15:0] ang);
    cordic_t c;
    logic signed [CordicW-1:0] z;
    z     = $signed({ang[15], ang, 17'b0});
    c.x   = GainQ30;
    c.y   = '0;
    c.neg = 1'b0;
    c.z   = z;
    if (z > HalfPiQ30) begin
      c.z   = z - PiQ30;
      c.neg = 1'b1;
    end else if (z < -HalfPiQ30) begin
      c.z   = z + PiQ30;
      c.neg = 1'b1;
    end
    return c;
  endfunction

  logic    cv   [NS+1];
  cordic_t yaw_c [NS+1];
  cordic_t roll_c[NS+1];
  side_t   side_q[NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      yaw_c[0]           <= seed(in_i.data.yaw_angle);
      roll_c[0]          <= seed(in_i.data.roll_angle);
      side_q[0].len      <= in_i.data.obj_length;
      side_q[0].wid      <= in_i.data.obj_width;
      side_q[0].hgt      <= in_i.data.obj_height;
      side_q[0].roll_neg <= in_i.data.roll_angle < 0;
      side_q[0].roll_pos <= in_i.data.roll_angle > 0;
      side_q[0].ref_x    <= in_i.data.ref_x;
      side_q[0].ref_y    <= in_i.data.ref_y;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    obc_cordic_stage #(.SHIFT(i)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cv[i]),
      .yaw_i   (yaw_c[i]),
      .roll_i  (roll_c[i]),
      .valid_o (cv[i+1]),
      .yaw_o   (yaw_c[i+1]),
      .roll_o  (roll_c[i+1])
    );

    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[i+1] <= side_q[i];
      end
    end
  end

  // Rounding to Q16.
  function automatic logic signed [17:0] to_q16(input logic signed [CordicW-1:0] v,
                                               input logic neg);
    logic signed [CordicW-1:0] t;
    t = neg ? -v : v;
    t = (t + 34'sd8192) >>> 14;
    return t[17:0];
  endfunction

  logic               r_valid_q;
  side_t              r_side_q;
  logic signed [17:0] sy_q, cy_q, sr_q, cr_q;

  // First multiplier stage.
  logic               m1_valid_q;
  side_t              m1_side_q;
  logic signed [17:0] m1_sy_q, m1_cy_q;
  logic signed [34:0] base_q, hs_q, lx_q, ls_q;

  // Offset adder stage.
  logic               a_valid_q;
  side_t              a_side_q;
  logic signed [17:0] a_sy_q, a_cy_q;
  logic signed [36:0] wl_q, wr_q;
  logic signed [34:0] a_lx_q, a_ls_q;

  // Second multiplier stage.
  logic               m2_valid_q;
  side_t              m2_side_q;
  logic signed [54:0] wrs_q, wrc_q, wls_q, wlc_q;
  logic signed [34:0] m2_lx_q, m2_ls_q;

  // Offset rounding stage.
  logic               f1_valid_q;
  side_t              f1_side_q;
  logic signed [23:0] off_q [8];

  // Output register.
  logic               f2_valid_q;
  corners_t           out_q;

  logic signed [36:0] hs2;
  logic signed [56:0] lx16, ls16;
  logic signed [56:0] off_full [8];
  logic signed [56:0] off_rnd  [8];

  assign hs2  = 37'(hs_q) <<< 1;
  assign lx16 = 57'(m2_lx_q) <<< 16;
  assign ls16 = 57'(m2_ls_q) <<< 16;

  always_comb begin
    off_full[0] = -lx16 + 57'(wrs_q);
    off_full[1] = -ls16 - 57'(wrc_q);
    off_full[2] = -lx16 - 57'(wls_q);
    off_full[3] = -ls16 + 57'(wlc_q);
    off_full[4] =  lx16 - 57'(wls_q);
    off_full[5] =  ls16 + 57'(wlc_q);
    off_full[6] =  lx16 + 57'(wrs_q);
    off_full[7] =  ls16 - 57'(wrc_q);
    for (int k = 0; k < 8; k++) begin
      off_rnd[k] = (off_full[k] + 57'sd4294967296) >>> 33;
    end
  end

  function automatic logic signed [23:0] place(input logic signed [23:0] off,
                                              input logic signed [23:0] ref_v);
    logic signed [25:0] s;
    s = 26'(off) + 26'(ref_v);
    if (s > OutMax) begin
      s = OutMax;
    end else if (s < OutMin) begin
      s = OutMin;
    end
    return s[23:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q  <= 1'b0;
      m1_valid_q <= 1'b0;
      a_valid_q  <= 1'b0;
      m2_valid_q <= 1'b0;
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else if (en) begin
      r_valid_q  <= cv[NS];
      m1_valid_q <= r_valid_q;
      a_valid_q  <= m1_valid_q;
      m2_valid_q <= a_valid_q;
      f1_valid_q <= m2_valid_q;
      f2_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_side_q <= side_q[NS];
      cy_q     <= to_q16(yaw_c[NS].x, yaw_c[NS].neg);
      sy_q     <= to_q16(yaw_c[NS].y, yaw_c[NS].neg);
      cr_q     <= to_q16(roll_c[NS].x, roll_c[NS].neg);
      sr_q     <= to_q16(roll_c[NS].y, roll_c[NS].neg);

      m1_side_q <= r_side_q;
      m1_sy_q   <= sy_q;
      m1_cy_q   <= cy_q;
      base_q    <= $signed({1'b0, r_side_q.wid}) * cr_q;
      hs_q      <= $signed({1'b0, r_side_q.hgt}) * sr_q;
      lx_q      <= $signed({1'b0, r_side_q.len}) * cy_q;
      ls_q      <= $signed({1'b0, r_side_q.len}) * sy_q;

      a_side_q <= m1_side_q;
      a_sy_q   <= m1_sy_q;
      a_cy_q   <= m1_cy_q;
      a_lx_q   <= lx_q;
      a_ls_q   <= ls_q;
      wl_q     <= m1_side_q.roll_neg ? 37'(base_q) - hs2 : 37'(base_q);
      wr_q     <= m1_side_q.roll_pos ? 37'(base_q) + hs2 : 37'(base_q);

      m2_side_q <= a_side_q;
      m2_lx_q   <= a_lx_q;
      m2_ls_q   <= a_ls_q;
      wrs_q     <= wr_q * a_sy_q;
      wrc_q     <= wr_q * a_cy_q;
      wls_q     <= wl_q * a_sy_q;
      wlc_q     <= wl_q * a_cy_q;

      f1_side_q <= m2_side_q;
      for (int k = 0; k < 8; k++) begin
        off_q[k] <= off_rnd[k][23:0];
      end

      out_q.rear_right_x  <= place(off_q[0], f1_side_q.ref_x);
      out_q.rear_right_y  <= place(off_q[1], f1_side_q.ref_y);
      out_q.rear_left_x   <= place(off_q[2], f1_side_q.ref_x);
      out_q.rear_left_y   <= place(off_q[3], f1_side_q.ref_y);
      out_q.front_left_x  <= place(off_q[4], f1_side_q.ref_x);
      out_q.front_left_y  <= place(off_q[5], f1_side_q.ref_y);
      out_q.front_right_x <= place(off_q[6], f1_side_q.ref_x);
      out_q.front_right_y <= place(off_q[7], f1_side_q.ref_y);
    end
  end

  assign en         = !f2_valid_q || out_o.ready;
  assign in_i.ready = en;
  assign out_o.valid = f2_valid_q;
  assign out_o.data  = out_q;

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f2_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted while the output word is stalled");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> cv[0])
    else $error("accepted pose did not enter the pipeline");

  a_cos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_valid_q |-> (cy_q <= 18'sd65600 && cy_q >= -18'sd65600 &&
                   cr_q <= 18'sd65600 && cr_q >= -18'sd65600))
    else $error("CORDIC cosine outside the unit range");

endmodule

`default_nettype wire

@@ tb/sv/tb_oriented_box_corners_core.sv @@
// Self-checking testbench for oriented_box_corners_core: drives pose words, predicts corners.
// Depends on obc_pkg, obc_if and the core RTL; uses a small scoreboard class for checking.
`default_nettype none

module tb_oriented_box_corners_core;
  import obc_pkg::*;

  localparam int unsigned Stages  = 16;
  localparam int unsigned Latency = Stages + 7;
  localparam int unsigned NumRand = 1750;

  localparam longint PiQ30L     = 64'sd3373259426;
  localparam longint HalfPiQ30L = 64'sd1686629713;
  localparam longint GainQ30L   = 64'sd652032874;
  localparam longint MaxQ8      = 64'sd8388607;
  localparam longint MinQ8      = -64'sd8388608;

  logic clk_i;
  logic rst_ni;

  obc_in_if  pose_ch ();
  obc_out_if corner_ch ();

  oriented_box_corners_core #(.CORDIC_STAGES(Stages)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (pose_ch),
    .out_o (corner_ch)
  );

  int unsigned error_count;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
  endtask

  function automatic longint floor_shift(input longint v, input int unsigned s);
    return v >>> s;
  endfunction

  function automatic longint arctan_entry(input int unsigned i);
    return longint'(atan_q30(i[4:0]));
  endfunction

  // Sine and cosine of a Q3.13 angle in Q16, as the rotation-mode CORDIC produces them.
  function automatic void sin_cos_q16(input logic signed [15:0] ang, output longint sn,
                                      output longint cs);
    longint z, x, y, t;
    bit     flip;
    z    = longint'(ang) * 131072;
    x    = GainQ30L;
    y    = 0;
    flip = 1'b0;
    if (z > HalfPiQ30L) begin
      z -= PiQ30L;
      flip = 1'b1;
    end else if (z < -HalfPiQ30L) begin
      z += PiQ30L;
      flip = 1'b1;
    end
    for (int unsigned i = 0; i < Stages && i < MaxStages; i++) begin
      if (z >= 0) begin
        t = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z -= arctan_entry(i);
      end else begin
        t = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z += arctan_entry(i);
      end
      x = t;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cs = floor_shift(x + 8192, 14);
    sn = floor_shift(y + 8192, 14);
  endfunction

  function automatic logic signed [23:0] place_corner(input longint off, input longint ref_q8);
    longint v;
    v = floor_shift(off + 64'sd4294967296, 33) + ref_q8;
    if (v > MaxQ8) v = MaxQ8;
    if (v < MinQ8) v = MinQ8;
    return v[23:0];
  endfunction

  function automatic void predict_corners(input pose_t p, output corners_t c);
    longint sy, cy, sr, cr, base, wl, wr, front;
    longint px[4], py[4];
    logic signed [23:0] cx[4], cyv[4];
    sin_cos_q16(p.yaw_angle, sy, cy);
    sin_cos_q16(p.roll_angle, sr, cr);
    base = longint'(p.obj_width) * cr;
    wl = base;
    wr = base;
    if (p.roll_angle < 0) wl += -(longint'(p.obj_height) * sr) * 2;
    if (p.roll_angle > 0) wr += (longint'(p.obj_height) * sr) * 2;
    front = longint'(p.obj_length) * 65536;
    px[0] = -front; py[0] = -wr;
    px[1] = -front; py[1] = wl;
    px[2] = front;  py[2] = wl;
    px[3] = front;  py[3] = -wr;
    for (int k = 0; k < 4; k++) begin
      cx[k]  = place_corner(px[k] * cy - py[k] * sy, longint'(p.ref_x));
      cyv[k] = place_corner(px[k] * sy + py[k] * cy, longint'(p.ref_y));
    end
    c.rear_right_x  = cx[0]; c.rear_right_y  = cyv[0];
    c.rear_left_x   = cx[1]; c.rear_left_y   = cyv[1];
    c.front_left_x  = cx[2]; c.front_left_y  = cyv[2];
    c.front_right_x = cx[3]; c.front_right_y = cyv[3];
  endfunction

  class corner_scoreboard;
    corners_t    pending[$];
    int unsigned checked;

    function void note_pose(input pose_t p);
      corners_t c;
      predict_corners(p, c);
      pending.push_back(c);
    endfunction

    task check_corners(input corners_t got);
      corners_t w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected corner word", 0, 0);
        return;
      end
      w = pending.pop_front();
      checked++;
      if (got.rear_right_x !== w.rear_right_x)
        report_mismatch("rear_right_x", got.rear_right_x, w.rear_right_x);
      if (got.rear_right_y !== w.rear_right_y)
        report_mismatch("rear_right_y", got.rear_right_y, w.rear_right_y);
      if (got.rear_left_x !== w.rear_left_x)
        report_mismatch("rear_left_x", got.rear_left_x, w.rear_left_x);
      if (got.rear_left_y !== w.rear_left_y)
        report_mismatch("rear_left_y", got.rear_left_y, w.rear_left_y);
      if (got.front_left_x !== w.front_left_x)
        report_mismatch("front_left_x", got.front_left_x, w.front_left_x);
      if (got.front_left_y !== w.front_left_y)
        report_mismatch("front_left_y", got.front_left_y, w.front_left_y);
      if (got.front_right_x !== w.front_right_x)
        report_mismatch("front_right_x", got.front_right_x, w.front_right_x);
      if (got.front_right_y !== w.front_right_y)
        report_mismatch("front_right_y", got.front_right_y, w.front_right_y);
    endtask
  endclass

  corner_scoreboard sb;
  int unsigned      idle_pct;
  int unsigned      hold_cycles;
  int unsigned      poses_sent;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  initial begin
    #100000000;
    $display("Mismatches found");
    $finish;
  end

  // The sink deasserts ready at random, and holds it low for a long stretch on request.
  initial begin
    corner_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && corner_ch.valid && corner_ch.ready) sb.check_corners(corner_ch.data);
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        corner_ch.ready <= 1'b0;
      end else begin
        corner_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  task automatic send_pose(input pose_t p);
    while ($urandom_range(99) < idle_pct) begin
      pose_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    pose_ch.valid <= 1'b1;
    pose_ch.data  <= p;
    do @(posedge clk_i); while (!pose_ch.ready);
    sb.note_pose(p);
    poses_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_fields(input logic [15:0] len, input logic [15:0] wid,
                             input logic [15:0] hgt, input logic signed [15:0] yaw,
                             input logic signed [15:0] roll, input logic signed [23:0] rx,
                             input logic signed [23:0] ry);
    pose_t p;
    p.obj_length = len; p.obj_width = wid; p.obj_height = hgt;
    p.yaw_angle = yaw; p.roll_angle = roll; p.ref_x = rx; p.ref_y = ry;
    send_pose(p);
  endtask

  function automatic logic signed [15:0] pick_angle();
    case ($urandom_range(5))
      0: return 16'($signed($urandom_range(51472)) - 25736);
      1: return 16'($urandom);
      2: return 16'($signed($urandom_range(100)) - 50);
      3: return 16'($signed($urandom_range(12868 + 40, 12868 - 40)) *
                    ($urandom_range(1) ? 1 : -1));
      default: return 16'($signed($urandom_range(25736 + 40, 25736 - 40)) *
                          ($urandom_range(1) ? 1 : -1));
    endcase
  endfunction

  function automatic logic [15:0] pick_size();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return ($urandom_range(1) ? 16'hFFFF : 16'h0000);
      default: return 16'($urandom_range(2048));
    endcase
  endfunction

  function automatic logic signed [23:0] pick_pos();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return ($urandom_range(1) ? 24'sh7FFFFF : 24'sh800000);
      default: return 24'($signed($urandom_range(40000)) - 20000);
    endcase
  endfunction

  task automatic wait_drained();
    pose_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    pose_t p;
    sb            = new();
    error_count   = 0;
    idle_pct      = 22;
    hold_cycles   = 0;
    poses_sent    = 0;
    rst_ni        = 1'b0;
    pose_ch.valid = 1'b0;
    pose_ch.data  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: size and position extremes, angle reduction, steep roll, saturation.
    send_fields(16'h0000, 16'h0000, 16'h0000, 16'sd0, 16'sd0, 24'sd0, 24'sd0);
    send_fields(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sd0, 16'sd0, 24'sd0, 24'sd0);
    send_fields(16'h0400, 16'h0200, 16'h0300, 16'sd12868, 16'sd0, 24'sd100, -24'sd100);
    send_fields(16'h0400, 16'h0200, 16'h0300, -16'sd12868, 16'sd0, 24'sd0, 24'sd0);
    send_fields(16'h0400, 16'h0200, 16'h0300, 16'sd12869, 16'sd0, 24'sd0, 24'sd0);
    send_fields(16'h0400, 16'h0200, 16'h0300, 16'sd25736, 16'sd0, 24'sd0, 24'sd0);
    send_fields(16'h0400, 16'h0200, 16'h0300, -16'sd25736, 16'sd0, 24'sd0, 24'sd0);
    send_fields(16'h0400, 16'h0200, 16'h0300, 16'sh7FFF, 16'sh8000, 24'sd0, 24'sd0);
    send_fields(16'h0400, 16'h0200, 16'h0300, 16'sh8000, 16'sh7FFF, 24'sd0, 24'sd0);
    send_fields(16'h0400, 16'h0200, 16'h0300, 16'sd0, 16'sd2000, 24'sd0, 24'sd0);
    send_fields(16'h0400, 16'h0200, 16'h0300, 16'sd0, -16'sd2000, 24'sd0, 24'sd0);
    send_fields(16'h0400, 16'h0200, 16'h0300, 16'sd0, 16'sd20000, 24'sd0, 24'sd0);
    send_fields(16'h0400, 16'h0200, 16'h0300, 16'sd0, -16'sd20000, 24'sd0, 24'sd0);
    send_fields(16'h0400, 16'h0200, 16'h0300, 16'sd1, -16'sd1, 24'sd0, 24'sd0);
    send_fields(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sd6434, 16'sd6434, 24'sh7FFFFF, 24'sh7FFFFF);
    send_fields(16'hFFFF, 16'hFFFF, 16'hFFFF, -16'sd19302, -16'sd6434, 24'sh800000,
                24'sh800000);
    send_fields(16'h0000, 16'h0000, 16'h0000, 16'sd0, 16'sd0, 24'sh7FFFFF, 24'sh800000);
    send_fields(16'hAAAA, 16'h5555, 16'hAAAA, 16'sh5555, 16'shAAAA, 24'shAAAAAA,
                24'sh555555);
    send_fields(16'h5555, 16'hAAAA, 16'h5555, 16'shAAAA, 16'sh5555, 24'sh555555,
                24'shAAAAAA);
    wait_drained();

    for (int n = 0; n < NumRand; n++) begin
      idle_pct = (n >= 300 && n < 500) ? 0 : 22;
      if (n == 700) hold_cycles = 200;
      if (n == 1200) wait_drained();
      p.obj_length = pick_size();
      p.obj_width  = pick_size();
      p.obj_height = pick_size();
      p.yaw_angle  = pick_angle();
      p.roll_angle = pick_angle();
      p.ref_x      = pick_pos();
      p.ref_y      = pick_pos();
      send_pose(p);
    end

    wait_drained();
    repeat (Latency + 10) @(negedge clk_i);
    $display("Sent %0d poses with directed extremes and random angles, sizes and positions;",
             poses_sent);
    $display("checked %0d corner words under random stalls and a long output hold.",
             sb.checked);
    if (error_count == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
